[sv/lane_signal_phase_controller_assert.svh]
// Assertion macros shared by the checker of lane_signal_phase_controller.
`ifndef LANE_SIGNAL_PHASE_CONTROLLER_ASSERT_SVH
`define LANE_SIGNAL_PHASE_CONTROLLER_ASSERT_SVH

// Checked only out of reset.
`define LSPC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LSPC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/lspc_pkg.sv]
package lspc_pkg;

	localparam int unsigned LANE_W   = 8;
	localparam int unsigned UNLOAD_W = 4;
	localparam int unsigned PHASE_W  = 5;
	localparam int unsigned TICK_W   = 8;
	localparam int unsigned CREDIT_W = 2;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CREDIT_W-1:0] CREDIT_RELOAD = 2'd2;

	// mode codes; code 3 behaves as adaptive
	localparam logic [MODE_W-1:0] MODE_FIXED_A  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIXED_B  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ADAPTIVE = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_GREEN  = 3'd1,
		REG_PAUSE  = 3'd2,
		REG_UNLOAD = 3'd3,
		REG_PAIR   = 3'd4
	} cfg_reg_t;

	localparam logic [LANE_W-1:0] LANES_15 = 8'h11;
	localparam logic [LANE_W-1:0] LANES_26 = 8'h22;
	localparam logic [LANE_W-1:0] LANES_37 = 8'h44;
	localparam logic [LANE_W-1:0] LANES_48 = 8'h88;
	localparam logic [LANE_W-1:0] LANES_12 = 8'h03;
	localparam logic [LANE_W-1:0] LANES_56 = 8'h30;
	localparam logic [LANE_W-1:0] LANES_78 = 8'hC0;
	localparam logic [LANE_W-1:0] LANES_34 = 8'h0C;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TICK_W-1:0] green_ticks;
		logic [TICK_W-1:0] pause_ticks;
		logic [TICK_W-1:0] unload_ticks;
		logic [TICK_W-1:0] pair_ticks;
	} cfg_t;

	typedef struct packed {
		logic [LANE_W-1:0]   lamps;
		logic [PHASE_W-1:0]  phase;
		logic [TICK_W-1:0]   timer;
		logic [CREDIT_W-1:0] unload_credit;
		logic [CREDIT_W-1:0] straight_credit;
		logic [CREDIT_W-1:0] pair_credit;
	} ctl_state_t;

	// lane pair served by green slot idx of a fixed cycle
	function automatic logic [LANE_W-1:0] fixed_pair(input logic sel, input logic [1:0] idx);
		logic [LANE_W-1:0] m;
		unique case (idx)
			2'd0: m = sel ? LANES_12 : LANES_15;
			2'd1: m = sel ? LANES_56 : LANES_37;
			2'd2: m = sel ? LANES_78 : LANES_26;
			default: m = sel ? LANES_34 : LANES_48;
		endcase
		return m;
	endfunction

endpackage

[sv/lane_signal_phase_controller.sv]
// An accepted tick passes the input register, then the result register with the
// updated phase state, before its result shows on m_tdata.
// Throughput: one tick per cycle while the receiver keeps m_tready high; the
// phase/timer/credit update is one combinational pass between those two registers.
// Reset (arst_n low, asynchronous): phase 1, timer 0, credits 2, lamps off,
// configuration to its defaults, both channels empty.
module lane_signal_phase_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] lane_request, [11:8] unload_flag, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] lamps, [12:8] phase, [20:13] timer, [23:21] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	lspc_pkg::cfg_t       cfg;
	lspc_pkg::ctl_state_t st_q, st_nxt;

	logic                              valid_s1;
	logic [lspc_pkg::LANE_W-1:0]       lane_s1;
	logic [lspc_pkg::UNLOAD_W-1:0]     unload_s1;
	logic                              m_valid_q;
	logic [23:0]                       m_data_q;
	logic                              adv;

	lspc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lspc_phase_logic u_logic (
		.cfg          (cfg),
		.cur          (st_q),
		.lane_request (lane_s1),
		.unload_flag  (unload_s1),
		.nxt          (st_nxt)
	);

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			lane_s1   <= s_tdata[7:0];
			unload_s1 <= s_tdata[11:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.lamps           <= '0;
			st_q.phase           <= 5'd1;
			st_q.timer           <= '0;
			st_q.unload_credit   <= lspc_pkg::CREDIT_RELOAD;
			st_q.straight_credit <= lspc_pkg::CREDIT_RELOAD;
			st_q.pair_credit     <= lspc_pkg::CREDIT_RELOAD;
			m_valid_q            <= 1'b0;
		end else if (adv) begin
			st_q      <= st_nxt;
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			m_data_q <= {3'b000, st_nxt.timer, st_nxt.phase, st_nxt.lamps};
	end

endmodule

[sv/lspc_cfg_regs.sv]
module lspc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lspc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lspc_pkg::TICK_W-1:0]       cfg_data,
	output lspc_pkg::cfg_t                    cfg
);

	lspc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= lspc_pkg::MODE_ADAPTIVE;
			cfg_q.green_ticks  <= 8'd15;
			cfg_q.pause_ticks  <= 8'd10;
			cfg_q.unload_ticks <= 8'd20;
			cfg_q.pair_ticks   <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			// indexes past the list are dropped
			unique case (cfg_index)
				lspc_pkg::REG_MODE:   cfg_q.mode <= cfg_data[lspc_pkg::MODE_W-1:0];
				lspc_pkg::REG_GREEN:  cfg_q.green_ticks <= cfg_data;
				lspc_pkg::REG_PAUSE:  cfg_q.pause_ticks <= cfg_data;
				lspc_pkg::REG_UNLOAD: cfg_q.unload_ticks <= cfg_data;
				lspc_pkg::REG_PAIR:   cfg_q.pair_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[sv/lspc_phase_logic.sv]
module lspc_phase_logic (
	input  lspc_pkg::cfg_t                   cfg,
	input  lspc_pkg::ctl_state_t             cur,
	input  logic [lspc_pkg::LANE_W-1:0]      lane_request,
	input  logic [lspc_pkg::UNLOAD_W-1:0]    unload_flag,
	output lspc_pkg::ctl_state_t             nxt
);

	logic       t0, sel, fixed_mode;
	logic [4:0] p;
	logic       x1, x2, x3, x4, x5, x6, x7, x8;
	logic       s13, s14, s15, s16;
	logic       a15, a26, s37, s48, p15, p26, uc, sc, pc;
	logic       known;
	logic [1:0] odd_idx, even_idx;
	lspc_pkg::ctl_state_t st;

	assign t0 = (cur.timer == '0);
	assign p  = cur.phase;
	assign fixed_mode = (cfg.mode == lspc_pkg::MODE_FIXED_A) ||
		(cfg.mode == lspc_pkg::MODE_FIXED_B);
	assign sel = (cfg.mode == lspc_pkg::MODE_FIXED_B);
	assign odd_idx  = p[2:1];
	assign even_idx = p[2:1] - 2'd1;

	assign {x8, x7, x6, x5, x4, x3, x2, x1} = lane_request;
	assign {s16, s15, s14, s13} = unload_flag;
	assign a15 = (x1 && s13) || (x5 && s14);
	assign a26 = (x2 && s15) || (x6 && s16);
	assign s37 = x3 || x7;
	assign s48 = x4 || x8;
	assign p15 = (x1 || x5) && !s13 && !s14;
	assign p26 = (x2 || x6) && !s15 && !s16;
	assign uc = (cur.unload_credit != '0);
	assign sc = (cur.straight_credit != '0);
	assign pc = (cur.pair_credit != '0);

	always_comb begin
		st = cur;
		known = 1'b1;
		if (fixed_mode) begin
			if (p >= 5'd1 && p <= 5'd7 && p[0]) begin
				st.lamps = '0;
				if ((p == 5'd1 || t0) &&
						((lane_request & lspc_pkg::fixed_pair(sel, odd_idx)) != '0)) begin
					st.phase = p + 5'd1;
					st.timer = cfg.green_ticks;
				end
			end else if (p >= 5'd2 && p <= 5'd8 && !p[0]) begin
				st.lamps = lspc_pkg::fixed_pair(sel, even_idx);
				if (t0) begin
					st.phase = p + 5'd1;
					st.timer = cfg.pause_ticks;
				end
			end else if (p == 5'd9) begin
				st.lamps = '0;
				if (t0)
					st.phase = 5'd1;
			end
		end else begin
			unique case (p)
				5'd2, 5'd13: st.lamps = lspc_pkg::LANES_15;
				5'd3, 5'd14: st.lamps = lspc_pkg::LANES_26;
				5'd6, 5'd11: st.lamps = lspc_pkg::LANES_48;
				5'd7, 5'd10: st.lamps = lspc_pkg::LANES_37;
				5'd1, 5'd4, 5'd5, 5'd8, 5'd9, 5'd12, 5'd15, 5'd16: st.lamps = '0;
				default: known = 1'b0;
			endcase
			if (known && t0) begin
				priority if (p == 5'd2) begin
					st.phase = 5'd4; st.timer = cfg.pause_ticks;
				end else if (p == 5'd3) begin
					st.phase = 5'd5; st.timer = cfg.pause_ticks;
				end else if (p == 5'd6) begin
					st.phase = 5'd8; st.timer = cfg.pause_ticks;
				end else if (p == 5'd7) begin
					st.phase = 5'd9; st.timer = cfg.pause_ticks;
				end else if (p == 5'd10 || p == 5'd11) begin
					st.phase = 5'd12; st.timer = cfg.pause_ticks;
				end else if (p == 5'd13) begin
					st.phase = 5'd15; st.timer = cfg.pause_ticks;
				end else if (p == 5'd14) begin
					st.phase = 5'd16; st.timer = cfg.pause_ticks;
				end else if ((p == 5'd1 || p == 5'd5) && a15 && uc) begin
					st.phase = 5'd2; st.timer = cfg.unload_ticks;
					st.unload_credit = cur.unload_credit - 2'd1;
				end else if ((p == 5'd1 || p == 5'd4) && a26 && uc) begin
					st.phase = 5'd3; st.timer = cfg.unload_ticks;
					st.unload_credit = cur.unload_credit - 2'd1;
				end else if (p == 5'd1 || p == 5'd4 || p == 5'd5) begin
					priority if (s37 && sc) begin
						st.phase = 5'd7; st.timer = cfg.green_ticks;
						st.straight_credit = cur.straight_credit - 2'd1;
					end else if (s48 && sc) begin
						st.phase = 5'd6; st.timer = cfg.green_ticks;
						st.straight_credit = cur.straight_credit - 2'd1;
					end else if (p != 5'd1) begin
						st.phase = 5'd1;
						st.unload_credit = lspc_pkg::CREDIT_RELOAD;
						st.straight_credit = lspc_pkg::CREDIT_RELOAD;
						st.pair_credit = lspc_pkg::CREDIT_RELOAD;
					end else begin
						// phase 1 keeps waiting for demand
					end
				end else if (p == 5'd8 && s37 && sc) begin
					st.phase = 5'd10; st.timer = cfg.green_ticks;
					st.straight_credit = cur.straight_credit - 2'd1;
				end else if (p == 5'd9 && s48 && sc) begin
					st.phase = 5'd11; st.timer = cfg.green_ticks;
					st.straight_credit = cur.straight_credit - 2'd1;
				end else if (p != 5'd15 && p15 && pc) begin
					st.phase = 5'd13; st.timer = cfg.pair_ticks;
					st.pair_credit = cur.pair_credit - 2'd1;
				end else if (p != 5'd16 && p26 && pc) begin
					st.phase = 5'd14; st.timer = cfg.pair_ticks;
					st.pair_credit = cur.pair_credit - 2'd1;
				end else begin
					// end of cycle: back to phase 1 with fresh credits
					st.phase = 5'd1;
					st.unload_credit = lspc_pkg::CREDIT_RELOAD;
					st.straight_credit = lspc_pkg::CREDIT_RELOAD;
					st.pair_credit = lspc_pkg::CREDIT_RELOAD;
				end
			end
		end
		// the timer counts down after any reload, unknown phases included
		nxt = st;
		if (st.timer != '0)
			nxt.timer = st.timer - 8'd1;
	end

endmodule

[sv/lspc_checker.sv]
`include "lane_signal_phase_controller_assert.svh"

module lspc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	`LSPC_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`LSPC_ASSERT(a_phase_range, clk, arst_n, m_tvalid |-> m_tdata[12:8] != 5'd0 && m_tdata[12:8] <= 5'd16, "phase out of range")
	`LSPC_ASSERT(a_lamp_pair, clk, arst_n, m_tvalid |-> $countones(m_tdata[7:0]) == 0 || $countones(m_tdata[7:0]) == 2, "lamps not a lane pair")
	`LSPC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind lane_signal_phase_controller lspc_checker u_lspc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[bench/lspc_phase_check.sv]
module lspc_phase_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] lane_request, [11:8] unload_flag, [15:12] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] lamps, [12:8] phase, [20:13] timer, [23:21] zero
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          pending
);

	localparam logic [lspc_pkg::TICK_W-1:0] GREEN_RESET  = 8'd15;
	localparam logic [lspc_pkg::TICK_W-1:0] PAUSE_RESET  = 8'd10;
	localparam logic [lspc_pkg::TICK_W-1:0] UNLOAD_RESET = 8'd20;
	localparam logic [lspc_pkg::TICK_W-1:0] PAIR_RESET   = 8'd10;

	// [cycle][green slot]
	localparam logic [1:0][3:0][lspc_pkg::LANE_W-1:0] CYCLE_PAIRS = {
		{lspc_pkg::LANES_34, lspc_pkg::LANES_78, lspc_pkg::LANES_56, lspc_pkg::LANES_12},
		{lspc_pkg::LANES_48, lspc_pkg::LANES_26, lspc_pkg::LANES_37, lspc_pkg::LANES_15}
	};

	typedef struct packed {
		logic [lspc_pkg::LANE_W-1:0]  lamps;
		logic [lspc_pkg::PHASE_W-1:0] phase;
		logic [lspc_pkg::TICK_W-1:0]  timer;
	} light_result_t;

	logic [lspc_pkg::MODE_W-1:0]   mode_q;
	logic [lspc_pkg::TICK_W-1:0]   green_t, pause_t, unload_t, pair_t;
	logic [lspc_pkg::PHASE_W-1:0]  phase_q;
	logic [lspc_pkg::TICK_W-1:0]   timer_q;
	logic [lspc_pkg::LANE_W-1:0]   lamp_q;
	logic [lspc_pkg::CREDIT_W-1:0] unload_cr, straight_cr, pair_cr;

	light_result_t lights_q[$];
	int ticks_seen, results_seen, mismatches;

	assign pending = ticks_seen - results_seen;
	assign errors  = mismatches;

	function automatic void enter_phase(input logic [lspc_pkg::PHASE_W-1:0] nxt,
			input logic [lspc_pkg::TICK_W-1:0] ticks);
		phase_q = nxt;
		timer_q = ticks;
	endfunction

	function automatic void reload_credits();
		phase_q     = 5'd1;
		unload_cr   = lspc_pkg::CREDIT_RELOAD;
		straight_cr = lspc_pkg::CREDIT_RELOAD;
		pair_cr     = lspc_pkg::CREDIT_RELOAD;
	endfunction

	function automatic void fixed_tick(input logic sel,
			input logic [lspc_pkg::LANE_W-1:0] req, input logic t0);
		logic [1:0] slot;
		if (phase_q >= 5'd1 && phase_q <= 5'd7 && phase_q[0]) begin
			slot = phase_q[2:1];
			lamp_q = '0;
			// phase 1 starts a green on demand, the other odd phases only on demand once timed out
			if ((phase_q == 5'd1 || t0) && (req & CYCLE_PAIRS[sel][slot]) != '0)
				enter_phase(phase_q + 5'd1, green_t);
		end else if (phase_q >= 5'd2 && phase_q <= 5'd8 && !phase_q[0]) begin
			slot = phase_q[2:1] - 2'd1;
			lamp_q = CYCLE_PAIRS[sel][slot];
			if (t0)
				enter_phase(phase_q + 5'd1, pause_t);
		end else if (phase_q == 5'd9) begin
			lamp_q = '0;
			if (t0)
				phase_q = 5'd1;
		end
	endfunction

	function automatic void adaptive_tick(input logic [lspc_pkg::LANE_W-1:0] req,
			input logic [lspc_pkg::UNLOAD_W-1:0] unl, input logic t0);
		logic a15, a26, s37, s48, p15, p26, uc, sc, pc;
		logic [lspc_pkg::PHASE_W-1:0] p;
		a15 = (req[0] && unl[0]) || (req[4] && unl[1]);
		a26 = (req[1] && unl[2]) || (req[5] && unl[3]);
		s37 = req[2] || req[6];
		s48 = req[3] || req[7];
		p15 = (req[0] || req[4]) && !unl[0] && !unl[1];
		p26 = (req[1] || req[5]) && !unl[2] && !unl[3];
		uc = unload_cr != '0;
		sc = straight_cr != '0;
		pc = pair_cr != '0;
		p = phase_q;

		case (p)
			5'd2, 5'd13: lamp_q = lspc_pkg::LANES_15;
			5'd3, 5'd14: lamp_q = lspc_pkg::LANES_26;
			5'd6, 5'd11: lamp_q = lspc_pkg::LANES_48;
			5'd7, 5'd10: lamp_q = lspc_pkg::LANES_37;
			5'd1, 5'd4, 5'd5, 5'd8, 5'd9, 5'd12, 5'd15, 5'd16: lamp_q = '0;
			default: return;   // no such phase: lamps and phase hold
		endcase
		if (!t0)
			return;

		case (p)
			5'd2: begin
				enter_phase(5'd4, pause_t);
				return;
			end
			5'd3: begin
				enter_phase(5'd5, pause_t);
				return;
			end
			5'd6: begin
				enter_phase(5'd8, pause_t);
				return;
			end
			5'd7: begin
				enter_phase(5'd9, pause_t);
				return;
			end
			5'd10, 5'd11: begin
				enter_phase(5'd12, pause_t);
				return;
			end
			5'd13: begin
				enter_phase(5'd15, pause_t);
				return;
			end
			5'd14: begin
				enter_phase(5'd16, pause_t);
				return;
			end
			default: ;
		endcase

		if ((p == 5'd1 || p == 5'd5) && a15 && uc) begin
			enter_phase(5'd2, unload_t);
			unload_cr = unload_cr - 2'd1;
			return;
		end
		if ((p == 5'd1 || p == 5'd4) && a26 && uc) begin
			enter_phase(5'd3, unload_t);
			unload_cr = unload_cr - 2'd1;
			return;
		end
		if (p == 5'd1 || p == 5'd4 || p == 5'd5) begin
			if (s37 && sc) begin
				enter_phase(5'd7, green_t);
				straight_cr = straight_cr - 2'd1;
			end else if (s48 && sc) begin
				enter_phase(5'd6, green_t);
				straight_cr = straight_cr - 2'd1;
			end else if (p != 5'd1) begin
				reload_credits();
			end
			return;
		end
		if (p == 5'd8 && s37 && sc) begin
			enter_phase(5'd10, green_t);
			straight_cr = straight_cr - 2'd1;
			return;
		end
		if (p == 5'd9 && s48 && sc) begin
			enter_phase(5'd11, green_t);
			straight_cr = straight_cr - 2'd1;
			return;
		end
		if (p != 5'd15 && p15 && pc) begin
			enter_phase(5'd13, pair_t);
			pair_cr = pair_cr - 2'd1;
			return;
		end
		if (p != 5'd16 && p26 && pc) begin
			enter_phase(5'd14, pair_t);
			pair_cr = pair_cr - 2'd1;
			return;
		end
		reload_credits();
	endfunction

	function automatic light_result_t next_lights(input logic [lspc_pkg::LANE_W-1:0] req,
			input logic [lspc_pkg::UNLOAD_W-1:0] unl);
		light_result_t res;
		logic t0;
		t0 = timer_q == '0;
		if (mode_q == lspc_pkg::MODE_FIXED_A || mode_q == lspc_pkg::MODE_FIXED_B)
			fixed_tick(mode_q == lspc_pkg::MODE_FIXED_B, req, t0);
		else
			adaptive_tick(req, unl, t0);
		if (timer_q != '0)
			timer_q = timer_q - 8'd1;
		res.lamps = lamp_q;
		res.phase = phase_q;
		res.timer = timer_q;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		light_result_t got, want;
		if (!arst_n) begin
			mode_q   = lspc_pkg::MODE_ADAPTIVE;
			green_t  = GREEN_RESET;
			pause_t  = PAUSE_RESET;
			unload_t = UNLOAD_RESET;
			pair_t   = PAIR_RESET;
			timer_q  = '0;
			lamp_q   = '0;
			reload_credits();
			lights_q.delete();
			ticks_seen   <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lspc_pkg::REG_MODE:   mode_q   = cfg_data[lspc_pkg::MODE_W-1:0];
					lspc_pkg::REG_GREEN:  green_t  = cfg_data;
					lspc_pkg::REG_PAUSE:  pause_t  = cfg_data;
					lspc_pkg::REG_UNLOAD: unload_t = cfg_data;
					lspc_pkg::REG_PAIR:   pair_t   = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				lights_q.push_back(next_lights(s_tdata[7:0], s_tdata[11:8]));
				ticks_seen <= ticks_seen + 1;
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				got.lamps = m_tdata[7:0];
				got.phase = m_tdata[12:8];
				got.timer = m_tdata[20:13];
				if (lights_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result %0d: lamps %h phase %0d timer %0d",
							results_seen, got.lamps, got.phase, got.timer);
					mismatches++;
				end else begin
					want = lights_q.pop_front();
					if (got.lamps !== want.lamps || got.phase !== want.phase ||
							got.timer !== want.timer) begin
						if (mismatches < 10)
							$display({"result %0d mismatch: lamps %h/%h phase %0d/%0d ",
								"timer %0d/%0d (expected/actual)"},
								results_seen, want.lamps, got.lamps, want.phase, got.phase,
								want.timer, got.timer);
						mismatches++;
					end
				end
			end
		end
	end

endmodule

[bench/lane_signal_phase_controller_tb.sv]
module lane_signal_phase_controller_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	// index with no register behind it
	localparam logic [lspc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	int errors, pending;
	int ready_run = 0;
	int idle_cycles = 0;
	int reg_writes = 0;
	int settings_run = 0;
	bit full_speed = 1'b0;

	always #10 clk = ~clk;

	lane_signal_phase_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lspc_phase_check u_phase_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// receiver: runs of ready or stalled of random length, always ready at full speed
	always @(posedge clk) begin
		if (ready_run == 0) begin
			ready_run <= $urandom_range(1, 16);
			m_tready <= full_speed || ($urandom_range(0, 9) < 7);
		end else begin
			ready_run <= ready_run - 1;
			if (full_speed)
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results pending",
					idle_cycles, pending);
				$display("lane_signal_phase_controller_tb: done, errors");
				$finish;
			end
		end
	end

	function automatic logic [lspc_pkg::LANE_W-1:0] pick_lanes();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 8'(1 << $urandom_range(0, 7));
			3: return 8'((1 << $urandom_range(0, 7)) | (1 << $urandom_range(0, 7)));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [lspc_pkg::UNLOAD_W-1:0] pick_unload();
		if ($urandom_range(0, 3) == 0)
			return '0;
		return 4'($urandom);
	endfunction

	// {unload_flag, lane_request}: walks the adaptive cycle through every branch
	function automatic logic [11:0] walk_tick(input int k);
		case (k)
			1:  return 12'h101;   // unload lanes 1/5 from phase 1
			3:  return 12'hC22;   // unload lanes 2/6 from phase 4
			5:  return 12'h210;   // unload credit spent: restart
			6:  return 12'h044;
			7:  return 12'hFFF;
			8:  return 12'h088;
			10: return 12'h011;
			11: return 12'h022;
			12: return 12'h022;
			14: return 12'h0FF;   // pair credit spent: restart
			15: return 12'h080;
			17: return 12'h004;
			19: return 12'hFFF;
			default: return 12'h000;
		endcase
	endfunction

	task automatic send_tick(input logic [lspc_pkg::LANE_W-1:0] lanes,
			input logic [lspc_pkg::UNLOAD_W-1:0] unl);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, unl, lanes};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [lspc_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] mode_val, green, pause, unload, pair,
			input int n, input bit fast, input bit mode_only);
		int gap, burst_left, drain_at;
		drain_results();
		write_reg(lspc_pkg::REG_MODE, mode_val);
		if (!mode_only) begin
			write_reg(lspc_pkg::REG_GREEN, green);
			write_reg(lspc_pkg::REG_PAUSE, pause);
			write_reg(lspc_pkg::REG_UNLOAD, unload);
			write_reg(lspc_pkg::REG_PAIR, pair);
		end
		cfg_valid <= 1'b0;
		full_speed <= fast;
		settings_run++;
		burst_left = 0;
		drain_at = fast ? -1 : $urandom_range(n / 4, n - 1);
		for (int i = 0; i < n; i++) begin
			if (i == drain_at) begin
				drain_results();
			end else if (burst_left == 0 && !fast) begin
				gap = $urandom_range(1, 5);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (burst_left == 0)
				burst_left = $urandom_range(1, 12);
			burst_left--;
			send_tick(pick_lanes(), pick_unload());
		end
	endtask

	initial begin
		logic [11:0] item;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero durations: every tick of the walk after the first ends its phase
		write_reg(lspc_pkg::REG_MODE, {6'b0, lspc_pkg::MODE_ADAPTIVE});
		write_reg(lspc_pkg::REG_GREEN, 8'd0);
		write_reg(lspc_pkg::REG_PAUSE, 8'd0);
		write_reg(lspc_pkg::REG_UNLOAD, 8'd0);
		write_reg(lspc_pkg::REG_PAIR, 8'd0);
		cfg_valid <= 1'b0;
		settings_run++;
		for (int k = 0; k < 20; k++) begin
			item = walk_tick(k);
			send_tick(item[7:0], item[11:8]);
		end

		run_phase({6'b0, lspc_pkg::MODE_FIXED_A}, 8'd2, 8'd1, 8'd0, 8'd0, 50, 1'b0, 1'b0);
		run_phase({6'b0, lspc_pkg::MODE_FIXED_B}, 8'd0, 8'd3, 8'd5, 8'd7, 50, 1'b0, 1'b0);
		run_phase({6'b0, lspc_pkg::MODE_ADAPTIVE}, 8'd1, 8'd0, 8'd2, 8'd1, 70, 1'b0, 1'b0);
		// mode switch from wherever the adaptive cycle stopped
		run_phase({6'b0, lspc_pkg::MODE_FIXED_A}, 8'd0, 8'd0, 8'd0, 8'd0, 40, 1'b0, 1'b1);
		drain_results();
		write_reg(REG_SPARE, 8'hA5);
		cfg_valid <= 1'b0;
		run_phase(8'hFE, 8'd2, 8'd1, 8'd0, 8'd3, 60, 1'b0, 1'b0);
		run_phase(8'h03, 8'd0, 8'd1, 8'd0, 8'd3, 60, 1'b1, 1'b0);
		run_phase({6'b0, lspc_pkg::MODE_FIXED_B}, 8'd0, 8'd0, 8'd1, 8'd0, 50, 1'b0, 1'b0);
		run_phase({6'b0, lspc_pkg::MODE_ADAPTIVE}, 8'd255, 8'd255, 8'd255, 8'd255, 20,
			1'b0, 1'b0);

		drain_results();
		repeat (10) @(posedge clk);

		$display("covered %0d register writes over %0d settings: both fixed cycles, adaptive",
			reg_writes, settings_run);
		$display("credits, mode code 3, zero and full-scale durations, live mode change");
		if (errors == 0 && pending == 0)
			$display("lane_signal_phase_controller_tb: done, clean");
		else
			$display("lane_signal_phase_controller_tb: done, errors");
		$finish;
	end

endmodule
